/* hdl/rcw_pkg.sv */
`default_nettype none
package rcw_pkg;

	localparam int COORD_W = 8;
	localparam int CHAN_W = 8;
	localparam int NUM_CHAN = 3;
	localparam int PIXEL_W = NUM_CHAN * CHAN_W;
	localparam int SIZE_W = 9;
	localparam int GAIN_W = 12;
	localparam int BRIGHT_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam int TAP_COUNT = 5;
	localparam int TAP_CENTER = 2;
	localparam int TAP_CNT_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic idle;
		logic rd;
		logic mul;
		logic emit;
	} rcw_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic in_bad;
		logic in_load;
		logic rd_last;
		logic out_free;
	} rcw_sts_t;

endpackage
`default_nettype wire

/* hdl/rcw_in_if.sv */
`default_nettype none
interface rcw_in_if import rcw_pkg::*; ();
	logic valid;
	logic ready;
	logic op;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [CHAN_W-1:0] red_in;
	logic [CHAN_W-1:0] green_in;
	logic [CHAN_W-1:0] blue_in;

	modport source(output valid, op, col, row, red_in, green_in, blue_in, input ready);
	modport sink(input valid, op, col, row, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

/* hdl/rcw_out_if.sv */
`default_nettype none
interface rcw_out_if import rcw_pkg::*; ();
	logic valid;
	logic ready;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;
	logic bad_coord;

	modport source(output valid, red_out, green_out, blue_out, bad_coord, input ready);
	modport sink(input valid, red_out, green_out, blue_out, bad_coord, output ready);
endinterface
`default_nettype wire

/* hdl/rcw_ctrl.sv */
`default_nettype none
module rcw_ctrl import rcw_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire rcw_sts_t sts,
	output rcw_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_ACC = 3'd2;
	localparam logic [2:0] S_MUL = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (sts.in_valid) begin
					if (sts.in_bad) begin
						state_d = S_FIN;
					end else if (!sts.in_load) begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				if (sts.rd_last) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* hdl/rcw_datapath.sv */
`default_nettype none
module rcw_datapath import rcw_pkg::*; #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	rcw_in_if.sink req,
	rcw_out_if.source rsp,
	input wire rcw_cmd_t cmd,
	output rcw_sts_t sts
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WCAP = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
	localparam int HCAP = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
	localparam logic [SIZE_W-1:0] W_CAP = SIZE_W'(WCAP);
	localparam logic [SIZE_W-1:0] H_CAP = SIZE_W'(HCAP);
	localparam int ACC_W = 11;
	localparam int PROD_W = 24;

	function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [PROD_W-1:0] t);
		logic [CHAN_W-1:0] r;
		if (t[PROD_W-1]) begin
			r = '0;
		end else if (|t[PROD_W-2:16]) begin
			r = '1;
		end else begin
			r = t[15:8];
		end
		return r;
	endfunction

	// config registers
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [GAIN_W-1:0] gain_q;
	logic [BRIGHT_W-1:0] bright_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
			gain_q <= 12'd256;
			bright_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				REG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				REG_BRIGHTNESS: bright_q <= cfg_data[BRIGHT_W-1:0];
			endcase
		end
	end

	logic [SIZE_W-1:0] eff_w;
	logic [SIZE_W-1:0] eff_h;
	assign eff_w = (width_q > W_CAP) ? W_CAP : width_q;
	assign eff_h = (height_q > H_CAP) ? H_CAP : height_q;

	// input decode
	logic accept;
	logic in_bad;
	logic [31:0] row_base;
	logic [31:0] in_addr_w;
	logic signed [SIZE_W:0] sc0;
	logic signed [SIZE_W:0] sc1;
	logic signed [SIZE_W:0] sc2;

	assign req.ready = cmd.idle;
	assign accept = req.valid && cmd.idle;
	assign in_bad = ({1'b0, req.col} >= eff_w) || ({1'b0, req.row} >= eff_h);
	assign row_base = 32'(req.row) * 32'(MAX_WIDTH);
	assign in_addr_w = row_base + 32'(req.col);

	// first tap column, wrapped (twice for a width of one)
	always_comb begin
		sc0 = $signed({2'b00, req.col}) - 10'sd2;
		sc1 = (sc0 < 0) ? sc0 + $signed({1'b0, eff_w}) : sc0;
		sc2 = (sc1 < 0) ? sc1 + $signed({1'b0, eff_w}) : sc1;
	end

	// read sequencing
	logic [AW-1:0] base_q;
	logic [SIZE_W-1:0] c_q;
	logic [TAP_CNT_W-1:0] cnt_q;
	logic bad_q;
	logic [SIZE_W:0] c_inc;

	assign c_inc = {1'b0, c_q} + 10'd1;

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= row_base[AW-1:0];
			c_q <= sc2[SIZE_W-1:0];
			bad_q <= in_bad;
		end else if (cmd.rd) begin
			c_q <= (c_inc == {1'b0, eff_w}) ? '0 : c_inc[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (cmd.rd) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	// frame memory, single port
	logic [PIXEL_W-1:0] mem [DEPTH];
	logic [PIXEL_W-1:0] rdata_s1;
	logic [AW-1:0] mem_addr;
	logic mem_we;

	assign mem_we = accept && !in_bad && (req.op == OP_LOAD);
	assign mem_addr = cmd.rd ? base_q + AW'(c_q) : in_addr_w[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= {req.red_in, req.green_in, req.blue_in};
		end
		rdata_s1 <= mem[mem_addr];
	end

	logic rd_s1;
	logic center_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
		end
	end

	always_ff @(posedge clk) begin
		center_s1 <= (cnt_q == TAP_CNT_W'(TAP_CENTER));
	end

	// per channel accumulate, multiply, offset and clamp
	logic signed [ACC_W-1:0] acc_q [NUM_CHAN];
	logic signed [PROD_W-1:0] prod_q [NUM_CHAN];
	logic signed [PROD_W-1:0] bright_ext;
	logic [CHAN_W-1:0] res [NUM_CHAN];

	assign bright_ext = {{7{bright_q[BRIGHT_W-1]}}, bright_q, 8'h00};

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			if (accept) begin
				acc_q[ch] <= '0;
			end else if (rd_s1) begin
				acc_q[ch] <= acc_q[ch] + (center_s1
					? $signed({1'b0, rdata_s1[PIXEL_W-1-CHAN_W*ch -: CHAN_W], 2'b00})
					: -$signed({3'b000, rdata_s1[PIXEL_W-1-CHAN_W*ch -: CHAN_W]}));
			end
			if (cmd.mul) begin
				prod_q[ch] <= PROD_W'(acc_q[ch] * $signed({1'b0, gain_q}));
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			res[ch] = clamp_chan(prod_q[ch] + bright_ext);
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp.red_out <= bad_q ? '0 : res[0];
			rsp.green_out <= bad_q ? '0 : res[1];
			rsp.blue_out <= bad_q ? '0 : res[2];
			rsp.bad_coord <= bad_q;
		end
	end

	assign rsp.valid = out_valid_q;

	always_comb begin
		sts.in_valid = req.valid;
		sts.in_bad = in_bad;
		sts.in_load = (req.op == OP_LOAD);
		sts.rd_last = (cnt_q == TAP_CNT_W'(TAP_COUNT - 1));
		sts.out_free = !out_valid_q || rsp.ready;
	end

endmodule
`default_nettype wire

/* hdl/rgb_convolution_wraparound.sv */
`default_nettype none
// RGB frame store with a horizontal five-tap filter (4 at the center, -1 at column offsets
// -2, -1, +1 and +2, columns wrapping modulo image_width), then per channel
// clamp(trunc((sum*gain + brightness*256)/256), 0, 255) with gain in unsigned Q4.8.
// op 0 loads one pixel at (col, row); with a coordinate in range it gives no result and the
// block stays ready. op 1 returns one filtered pixel: five reads of the single-port frame
// memory, a step for the last read data, one multiply, then offset and clamp into the
// result register; the block takes no new request before it has emitted that result. A
// coordinate outside the configured size gives a single beat with bad_coord set and colors
// zero without reading the frame memory, and a bad load stores nothing. A beat still waiting
// in the output register holds the block in its last step until it is taken. Sizes above
// MAX_WIDTH/MAX_HEIGHT act as the maximum, a zero size makes every coordinate bad. A pixel
// must be loaded before any filter reads it. Configuration must be written only while the
// block is idle; the block itself does not enforce this. Registers: 0 image_width,
// 1 image_height, 2 gain, 3 brightness (signed).
module rgb_convolution_wraparound import rcw_pkg::*; #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	rcw_in_if.sink req,
	rcw_out_if.source rsp
);

	// command and status between sequencer and datapath
	rcw_cmd_t cmd;
	rcw_sts_t sts;

	// sequencer: idle, five reads, drain, multiply, emit
	rcw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sts(sts),
		.cmd(cmd)
	);

	// datapath: config registers, frame memory, accumulators, output register
	rcw_datapath #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req),
		.rsp(rsp),
		.cmd(cmd),
		.sts(sts)
	);

endmodule
`default_nettype wire
